FILE: src/lpbc_pkg.sv
`default_nettype none

package lpbc_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PIN   = 2'd2,
        CMD_UNPIN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_APPLY = 2'd2
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  table_id;
        logic [23:0] page_number;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        placed;
        logic        fetch_needed;
        logic        writeback_valid;
        logic [7:0]  writeback_table;
        logic [23:0] writeback_page;
    } rsp_t;

    typedef struct packed {
        logic        is_access;
        logic        is_write;
        logic        pin_value;
        logic [7:0]  table_id;
        logic [23:0] page_number;
    } job_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } job_ctl_t;

endpackage

`default_nettype wire

FILE: src/lru_page_buffer_controller_unit.sv
// A hit, pin or unpin word goes from the request queue through the idle and apply states
// to the result queue; a read or write miss also runs a victim scan over one slot a cycle.
// The engine takes a new word only in idle and only while the result queue has room.
// Request and result queues of two words each decouple both sides from the engine.
// Reset (rst_n, async, active low) clears all slot marks and ages at once and empties the queues.
`default_nettype none

module lru_page_buffer_controller_unit #(
    parameter int SLOTS     = 16,
    parameter int AGE_WIDTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire lpbc_pkg::req_t request,
    output logic                empty,
    input  wire logic           pop,
    output lpbc_pkg::rsp_t      result
);

    localparam int RSP_W = $bits(lpbc_pkg::rsp_t);

    lpbc_pkg::job_ctl_t job_ctl;
    lpbc_pkg::job_t     job;
    logic               job_pop;
    logic               out_full;
    logic               out_push;
    lpbc_pkg::rsp_t     rsp;
    logic [RSP_W-1:0]   out_bits;

    lpbc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .job_pop (job_pop),
        .job_ctl (job_ctl),
        .job     (job)
    );

    lpbc_back #(
        .SLOTS     (SLOTS),
        .AGE_WIDTH (AGE_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_ctl  (job_ctl),
        .job      (job),
        .job_pop  (job_pop),
        .out_full (out_full),
        .out_push (out_push),
        .rsp      (rsp)
    );

    lpbc_fifo #(
        .WIDTH (RSP_W),
        .DEPTH (2)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (rsp),
        .rd_en   (pop),
        .rd_data (out_bits),
        .full    (out_full),
        .empty   (empty)
    );

    assign result = out_bits;

endmodule

`default_nettype wire

FILE: src/lpbc_fifo.sv
`default_nettype none

module lpbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/lpbc_front.sv
`default_nettype none

module lpbc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire lpbc_pkg::req_t   request,
    input  wire logic             job_pop,
    output lpbc_pkg::job_ctl_t    job_ctl,
    output lpbc_pkg::job_t        job
);

    localparam int JOB_W = $bits(lpbc_pkg::job_t);

    lpbc_pkg::job_t   in_job;
    logic [JOB_W-1:0] head_bits;
    logic             queue_empty;

    always_comb
    begin
        in_job.is_access   = (request.command == lpbc_pkg::CMD_READ)
                          || (request.command == lpbc_pkg::CMD_WRITE);
        in_job.is_write    = (request.command == lpbc_pkg::CMD_WRITE);
        in_job.pin_value   = (request.command == lpbc_pkg::CMD_PIN);
        in_job.table_id    = request.table_id;
        in_job.page_number = request.page_number;
    end

    lpbc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_job),
        .rd_en   (job_pop),
        .rd_data (head_bits),
        .full    (full),
        .empty   (queue_empty)
    );

    assign job           = head_bits;
    assign job_ctl.valid = !queue_empty;
    assign job_ctl.pop   = job_pop;

endmodule

`default_nettype wire

FILE: src/lpbc_back.sv
`default_nettype none

module lpbc_back #(
    parameter int SLOTS     = 16,
    parameter int AGE_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lpbc_pkg::job_ctl_t job_ctl,
    input  wire lpbc_pkg::job_t     job,
    output logic                    job_pop,
    input  wire logic               out_full,
    output logic                    out_push,
    output lpbc_pkg::rsp_t          rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [AGE_WIDTH-1:0] AGE_MAX  = '1;

    logic                 valid_reg  [SLOTS];
    logic                 valid_next [SLOTS];
    logic                 dirty_reg  [SLOTS];
    logic                 dirty_next [SLOTS];
    logic                 pinned_reg [SLOTS];
    logic                 pinned_next[SLOTS];
    logic [AGE_WIDTH-1:0] age_reg    [SLOTS];
    logic [AGE_WIDTH-1:0] age_next   [SLOTS];
    logic [7:0]           table_reg  [SLOTS];
    logic [7:0]           table_next [SLOTS];
    logic [23:0]          page_reg   [SLOTS];
    logic [23:0]          page_next  [SLOTS];

    lpbc_pkg::state_t     state_reg;
    lpbc_pkg::state_t     state_next;
    lpbc_pkg::job_t       job_reg;
    lpbc_pkg::job_t       job_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     hit_idx_next;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     scan_idx_next;
    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_idx_next;
    logic [AGE_WIDTH-1:0] best_age_reg;
    logic [AGE_WIDTH-1:0] best_age_next;

    logic [SLOTS-1:0]     match;
    logic                 head_hit;
    logic [IDX_W-1:0]     head_idx;
    logic                 touch;
    logic [IDX_W-1:0]     used_idx;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = valid_reg[i] && (table_reg[i] == job.table_id)
                    && (page_reg[i] == job.page_number);
        end
        head_hit = |match;
        head_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                head_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        scan_idx_next = scan_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_age_next = best_age_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            valid_next[i]  = valid_reg[i];
            dirty_next[i]  = dirty_reg[i];
            pinned_next[i] = pinned_reg[i];
            age_next[i]    = age_reg[i];
            table_next[i]  = table_reg[i];
            page_next[i]   = page_reg[i];
        end
        job_pop  = 1'b0;
        out_push = 1'b0;
        rsp      = '0;
        touch    = 1'b0;
        used_idx = '0;

        case (state_reg)
            lpbc_pkg::ST_IDLE:
            begin
                if (job_ctl.valid && !out_full)
                begin
                    job_pop       = 1'b1;
                    job_next      = job;
                    hit_next      = head_hit;
                    hit_idx_next  = head_idx;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    best_idx_next = '0;
                    best_age_next = '0;
                    if (head_hit || !job.is_access)
                    begin
                        state_next = lpbc_pkg::ST_APPLY;
                    end
                    else
                    begin
                        state_next = lpbc_pkg::ST_SCAN;
                    end
                end
            end
            lpbc_pkg::ST_SCAN:
            begin
                if (!pinned_reg[scan_idx_reg]
                    && (!found_reg || (age_reg[scan_idx_reg] > best_age_reg)))
                begin
                    found_next    = 1'b1;
                    best_idx_next = scan_idx_reg;
                    best_age_next = age_reg[scan_idx_reg];
                end
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = lpbc_pkg::ST_APPLY;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            lpbc_pkg::ST_APPLY:
            begin
                out_push   = 1'b1;
                state_next = lpbc_pkg::ST_IDLE;
                if (!job_reg.is_access)
                begin
                    if (hit_reg)
                    begin
                        rsp.hit = 1'b1;
                        rsp.slot = 4'(hit_idx_reg);
                        pinned_next[hit_idx_reg] = job_reg.pin_value;
                    end
                end
                else if (hit_reg)
                begin
                    rsp.hit    = 1'b1;
                    rsp.slot   = 4'(hit_idx_reg);
                    rsp.placed = 1'b1;
                    if (job_reg.is_write)
                    begin
                        dirty_next[hit_idx_reg] = 1'b1;
                    end
                    touch    = 1'b1;
                    used_idx = hit_idx_reg;
                end
                else
                begin
                    rsp.fetch_needed = !job_reg.is_write;
                    if (!found_reg)
                    begin
                        if (job_reg.is_write)
                        begin
                            rsp.writeback_valid = 1'b1;
                            rsp.writeback_table = job_reg.table_id;
                            rsp.writeback_page  = job_reg.page_number;
                        end
                    end
                    else
                    begin
                        if (valid_reg[best_idx_reg] && dirty_reg[best_idx_reg])
                        begin
                            rsp.writeback_valid = 1'b1;
                            rsp.writeback_table = table_reg[best_idx_reg];
                            rsp.writeback_page  = page_reg[best_idx_reg];
                        end
                        valid_next[best_idx_reg]  = 1'b1;
                        table_next[best_idx_reg]  = job_reg.table_id;
                        page_next[best_idx_reg]   = job_reg.page_number;
                        pinned_next[best_idx_reg] = 1'b0;
                        dirty_next[best_idx_reg]  = job_reg.is_write;
                        rsp.slot   = 4'(best_idx_reg);
                        rsp.placed = 1'b1;
                        touch      = 1'b1;
                        used_idx   = best_idx_reg;
                    end
                end
            end
            default:
            begin
                state_next = lpbc_pkg::ST_IDLE;
            end
        endcase

        if (touch)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (age_reg[i] != AGE_MAX)
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
            age_next[used_idx] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lpbc_pkg::ST_IDLE;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
            best_age_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i]  <= 1'b0;
                dirty_reg[i]  <= 1'b0;
                pinned_reg[i] <= 1'b0;
                age_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            scan_idx_reg <= scan_idx_next;
            found_reg    <= found_next;
            best_idx_reg <= best_idx_next;
            best_age_reg <= best_age_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i]  <= valid_next[i];
                dirty_reg[i]  <= dirty_next[i];
                pinned_reg[i] <= pinned_next[i];
                age_reg[i]    <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        for (int i = 0; i < SLOTS; i++)
        begin
            table_reg[i] <= table_next[i];
            page_reg[i]  <= page_next[i];
        end
    end

`ifndef SYNTHESIS
    a_apply_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpbc_pkg::ST_IDLE && job_pop) |=> !out_full)
        else $error("result queue full when result is due");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (state_reg == lpbc_pkg::ST_IDLE && job_ctl.valid))
        else $error("job taken outside idle");

    a_scan_is_access_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpbc_pkg::ST_SCAN) |-> (!hit_reg && job_reg.is_access))
        else $error("victim scan for a hit or pin request");

    a_best_unpinned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpbc_pkg::ST_SCAN && found_reg) |-> !pinned_reg[best_idx_reg])
        else $error("victim candidate is pinned");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS     = 16;
    localparam int AGE_WIDTH = 16;
    localparam int POOL      = 24;
    localparam int RANDOM_WORDS = 1300;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        lpbc_pkg::req_t word;
        bit             known;
        lpbc_pkg::rsp_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic empty;
    logic pop;
    lpbc_pkg::req_t request;
    lpbc_pkg::rsp_t result;

    logic                 tag_ok   [SLOTS];
    logic [7:0]           tag_tbl  [SLOTS];
    logic [23:0]          tag_pg   [SLOTS];
    logic                 mark_dirty [SLOTS];
    logic                 mark_pin [SLOTS];
    logic [AGE_WIDTH-1:0] lru_age  [SLOTS];

    lpbc_pkg::rsp_t due_results[$];
    row_t directed_rows[$];

    logic [7:0]  pool_tbl [POOL];
    logic [23:0] pool_pg  [POOL];

    bit idle_on;
    int errors;
    int rx_seen;
    int n_words;
    int n_hits;
    int n_dirty_evict;
    int n_all_pinned;

    lru_page_buffer_controller_unit #(
        .SLOTS     (SLOTS),
        .AGE_WIDTH (AGE_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic lpbc_pkg::req_t make_req(lpbc_pkg::cmd_t c, logic [7:0] t,
                                                logic [23:0] p);
        lpbc_pkg::req_t w;
        w.command     = c;
        w.table_id    = t;
        w.page_number = p;
        return w;
    endfunction

    function automatic lpbc_pkg::rsp_t resolve_request(lpbc_pkg::req_t r);
        lpbc_pkg::rsp_t o;
        int i;
        int found;
        int victim;
        int used;
        logic [AGE_WIDTH-1:0] best;
        o = '0;
        found = -1;
        used = -1;
        for (i = 0; i < SLOTS; i++)
            if (found < 0 && tag_ok[i] && tag_tbl[i] == r.table_id
                && tag_pg[i] == r.page_number)
                found = i;
        if (r.command == lpbc_pkg::CMD_PIN || r.command == lpbc_pkg::CMD_UNPIN)
        begin
            if (found >= 0)
            begin
                o.hit = 1'b1;
                o.slot = found[3:0];
                mark_pin[found] = (r.command == lpbc_pkg::CMD_PIN);
            end
        end
        else if (found >= 0)
        begin
            o.hit = 1'b1;
            o.slot = found[3:0];
            o.placed = 1'b1;
            if (r.command == lpbc_pkg::CMD_WRITE)
                mark_dirty[found] = 1'b1;
            used = found;
        end
        else
        begin
            victim = -1;
            best = '0;
            for (i = 0; i < SLOTS; i++)
                if (!mark_pin[i] && (victim < 0 || lru_age[i] > best))
                begin
                    victim = i;
                    best = lru_age[i];
                end
            o.fetch_needed = (r.command == lpbc_pkg::CMD_READ);
            if (victim < 0)
            begin
                if (r.command == lpbc_pkg::CMD_WRITE)
                begin
                    o.writeback_valid = 1'b1;
                    o.writeback_table = r.table_id;
                    o.writeback_page  = r.page_number;
                end
            end
            else
            begin
                if (tag_ok[victim] && mark_dirty[victim])
                begin
                    o.writeback_valid = 1'b1;
                    o.writeback_table = tag_tbl[victim];
                    o.writeback_page  = tag_pg[victim];
                end
                tag_ok[victim]     = 1'b1;
                tag_tbl[victim]    = r.table_id;
                tag_pg[victim]     = r.page_number;
                mark_pin[victim]   = 1'b0;
                mark_dirty[victim] = (r.command == lpbc_pkg::CMD_WRITE);
                o.slot = victim[3:0];
                o.placed = 1'b1;
                used = victim;
            end
        end
        if (used >= 0)
        begin
            for (i = 0; i < SLOTS; i++)
                if (lru_age[i] != '1)
                    lru_age[i] = lru_age[i] + 1'b1;
            lru_age[used] = '0;
        end
        return o;
    endfunction

    task automatic row(lpbc_pkg::cmd_t c, logic [7:0] t, logic [23:0] p);
        row_t e;
        e.word = make_req(c, t, p);
        e.known = 1'b0;
        e.want = '0;
        directed_rows.push_back(e);
    endtask

    task automatic row_known(lpbc_pkg::cmd_t c, logic [7:0] t, logic [23:0] p,
                             logic h, logic [3:0] s, logic pl, logic f,
                             logic wv, logic [7:0] wt, logic [23:0] wp);
        row_t e;
        e.word = make_req(c, t, p);
        e.known = 1'b1;
        e.want.hit = h;
        e.want.slot = s;
        e.want.placed = pl;
        e.want.fetch_needed = f;
        e.want.writeback_valid = wv;
        e.want.writeback_table = wt;
        e.want.writeback_page = wp;
        directed_rows.push_back(e);
    endtask

    task automatic send_word(lpbc_pkg::req_t w, bit known, lpbc_pkg::rsp_t want);
        int gap;
        lpbc_pkg::rsp_t pred;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        request <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        pred = resolve_request(w);
        due_results.push_back(known ? want : pred);
        n_words++;
        if (pred.hit)
            n_hits++;
        if (pred.placed && pred.writeback_valid)
            n_dirty_evict++;
        if (!pred.placed
            && (w.command == lpbc_pkg::CMD_READ || w.command == lpbc_pkg::CMD_WRITE))
            n_all_pinned++;
    endtask

    task automatic send_random(lpbc_pkg::cmd_t c);
        send_word(make_req(c, 8'($urandom_range(0, 255)),
                           24'($urandom_range(0, 24'hFFFFFF))),
                  1'b0, '0);
    endtask

    initial
    begin : drain_results
        int stall;
        lpbc_pkg::rsp_t want;
        logic bad;
        pop = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 19) : 0;
            if (rx_seen == HOLD_AT)
                stall = HOLD_LEN;
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            rx_seen++;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word %0d: hit=%0d slot=%0d wb=%0d %02h/%06h",
                             rx_seen, result.hit, result.slot, result.writeback_valid,
                             result.writeback_table, result.writeback_page);
            end
            else
            begin
                want = due_results.pop_front();
                bad = (result.hit !== want.hit) || (result.slot !== want.slot)
                    || (result.placed !== want.placed)
                    || (result.fetch_needed !== want.fetch_needed)
                    || (result.writeback_valid !== want.writeback_valid)
                    || (result.writeback_table !== want.writeback_table)
                    || (result.writeback_page !== want.writeback_page);
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch word %0d: exp hit=%0d slot=%0d placed=%0d ",
                                  "fetch=%0d wb=%0d %02h/%06h, got hit=%0d slot=%0d ",
                                  "placed=%0d fetch=%0d wb=%0d %02h/%06h"},
                                 rx_seen, want.hit, want.slot, want.placed,
                                 want.fetch_needed, want.writeback_valid,
                                 want.writeback_table, want.writeback_page,
                                 result.hit, result.slot, result.placed,
                                 result.fetch_needed, result.writeback_valid,
                                 result.writeback_table, result.writeback_page);
                end
            end
        end
    end

    initial
    begin : issue_requests
        int i;
        int k;
        int r;
        bit drain_done;
        lpbc_pkg::req_t w;
        lpbc_pkg::cmd_t c;

        rst_n = 1'b0;
        push = 1'b0;
        request = '0;
        idle_on = 1'b1;
        errors = 0;
        rx_seen = 0;
        n_words = 0;
        n_hits = 0;
        n_dirty_evict = 0;
        n_all_pinned = 0;
        drain_done = 1'b0;
        for (i = 0; i < SLOTS; i++)
        begin
            tag_ok[i] = 1'b0;
            tag_tbl[i] = '0;
            tag_pg[i] = '0;
            mark_dirty[i] = 1'b0;
            mark_pin[i] = 1'b0;
            lru_age[i] = '0;
        end
        for (i = 0; i < POOL; i++)
        begin
            pool_tbl[i] = 8'($urandom_range(0, 255));
            pool_pg[i] = 24'($urandom_range(0, 24'hFFFFFF));
        end

        row_known(lpbc_pkg::CMD_PIN,   8'h00, 24'h000000,
                  1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'h00, 24'h000000);
        row_known(lpbc_pkg::CMD_READ,  8'h00, 24'h000000,
                  1'b0, 4'd0, 1'b1, 1'b1, 1'b0, 8'h00, 24'h000000);
        row_known(lpbc_pkg::CMD_WRITE, 8'hFF, 24'hFFFFFF,
                  1'b0, 4'd1, 1'b1, 1'b0, 1'b0, 8'h00, 24'h000000);
        row_known(lpbc_pkg::CMD_READ,  8'hFF, 24'hFFFFFF,
                  1'b1, 4'd1, 1'b1, 1'b0, 1'b0, 8'h00, 24'h000000);
        row(lpbc_pkg::CMD_WRITE, 8'h00, 24'h000000);
        row_known(lpbc_pkg::CMD_PIN,   8'hFF, 24'hFFFFFF,
                  1'b1, 4'd1, 1'b0, 1'b0, 1'b0, 8'h00, 24'h000000);
        row(lpbc_pkg::CMD_UNPIN, 8'h00, 24'h000000);
        row_known(lpbc_pkg::CMD_UNPIN, 8'h01, 24'h000001,
                  1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'h00, 24'h000000);
        row(lpbc_pkg::CMD_UNPIN, 8'hFF, 24'hFFFFFF);
        for (i = 0; i < 14; i++)
            row((i % 2) ? lpbc_pkg::CMD_WRITE : lpbc_pkg::CMD_READ,
                8'hA5 ^ i[7:0], 24'h5A5A5A ^ 24'(i << 4));
        row(lpbc_pkg::CMD_READ,  8'h80, 24'h800000);
        row(lpbc_pkg::CMD_WRITE, 8'h7F, 24'h7FFFFF);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[j])
            send_word(directed_rows[j].word, directed_rows[j].known, directed_rows[j].want);

        while (n_words - directed_rows.size() < RANDOM_WORDS)
        begin
            if (!drain_done && n_words - directed_rows.size() >= 600)
            begin
                // hold until drained, then release every pin and run a gapless burst
                push <= 1'b0;
                while (due_results.size() != 0) @(posedge clk);
                idle_on = 1'b0;
                for (i = 0; i < SLOTS; i++)
                    if (tag_ok[i] && mark_pin[i])
                        send_word(make_req(lpbc_pkg::CMD_UNPIN, tag_tbl[i], tag_pg[i]),
                                  1'b0, '0);
                repeat (20)
                    send_random($urandom_range(0, 1) ? lpbc_pkg::CMD_WRITE
                                                     : lpbc_pkg::CMD_READ);
                drain_done = 1'b1;
                idle_on = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                // pin every valid slot, send reads and writes while they are pinned, release most
                idle_on = ($urandom_range(0, 3) != 0);
                for (i = 0; i < SLOTS; i++)
                    if (tag_ok[i])
                        send_word(make_req(lpbc_pkg::CMD_PIN, tag_tbl[i], tag_pg[i]),
                                  1'b0, '0);
                repeat (8)
                begin
                    k = $urandom_range(0, POOL - 1);
                    c = $urandom_range(0, 1) ? lpbc_pkg::CMD_WRITE : lpbc_pkg::CMD_READ;
                    if ($urandom_range(0, 2) == 0)
                        send_word(make_req(c, pool_tbl[k], pool_pg[k]), 1'b0, '0);
                    else
                        send_random(c);
                end
                for (i = 0; i < SLOTS; i++)
                    if (tag_ok[i] && $urandom_range(0, 4) != 0)
                        send_word(make_req(lpbc_pkg::CMD_UNPIN, tag_tbl[i], tag_pg[i]),
                                  1'b0, '0);
            end
            else
            begin
                idle_on = ($urandom_range(0, 4) != 0);
                repeat (20)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        k = $urandom_range(0, POOL - 1);
                        pool_tbl[k] = 8'($urandom_range(0, 255));
                        pool_pg[k] = 24'($urandom_range(0, 24'hFFFFFF));
                    end
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        c = lpbc_pkg::CMD_READ;
                    else if (r < 70)
                        c = lpbc_pkg::CMD_WRITE;
                    else if (r < 85)
                        c = lpbc_pkg::CMD_PIN;
                    else
                        c = lpbc_pkg::CMD_UNPIN;
                    if ($urandom_range(0, 99) < 8)
                        send_random(lpbc_pkg::cmd_t'($urandom_range(0, 3)));
                    else
                    begin
                        k = $urandom_range(0, POOL - 1);
                        w = make_req(c, pool_tbl[k], pool_pg[k]);
                        send_word(w, 1'b0, '0);
                    end
                end
            end
        end

        push <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (2 * SLOTS + 8) @(posedge clk);

        $display("sent %0d requests over random gaps, a long result stall and a full drain",
                 n_words);
        $display("hits %0d, dirty evictions %0d, misses with all slots pinned %0d, errors %0d",
                 n_hits, n_dirty_evict, n_all_pinned, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
